[rtl/nnt_pkg.sv]
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants
// Field widths, op codes and the control/status bundles between the
// tour controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

  localparam int CITY_W    = 5;
  localparam int DIST_IN_W = 16;
  localparam int TOTAL_W   = 21;
  localparam int CFG_W     = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 21'h1FFFFF;
  localparam logic [CFG_W-1:0]   CFG_RESET = 6'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;      // write one distance entry
    logic run_init;     // visited set to city 0 only, latch city count
    logic emit_city;    // load output register with current city
    logic scan_start;   // reset column counter and best candidate
    logic scan_issue;   // read entry (current, column), step column
    logic step_upd;     // move to best city, add its distance
    logic close_issue;  // read entry (current, 0)
    logic close_add;    // add closing distance
    logic emit_final;   // load output register with the closing item
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take an item this cycle
    logic more_steps;   // unvisited cities remain
    logic scan_done;    // column being issued is the last one
  } sts_t;

endpackage

`default_nettype wire

[rtl/nnt_in_if.sv]
// ----------------------------------------------------------------------------
// nnt_in_if: input channel
// Valid/ready channel carrying one load or run item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnt_in_if;
  import nnt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [CITY_W-1:0]    from_city;
  logic [CITY_W-1:0]    to_city;
  logic [DIST_IN_W-1:0] distance;

  modport source (output valid, output op, output from_city, output to_city,
                  output distance, input ready);
  modport sink   (input valid, input op, input from_city, input to_city,
                  input distance, output ready);
endinterface

`default_nettype wire

[rtl/nnt_out_if.sv]
// ----------------------------------------------------------------------------
// nnt_out_if: result channel
// Valid/ready channel carrying one city of the tour.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnt_out_if;
  import nnt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CITY_W-1:0]  city;
  logic [TOTAL_W-1:0] total_distance;
  logic               last;

  modport source (output valid, output city, output total_distance,
                  output last, input ready);
  modport sink   (input valid, input city, input total_distance,
                  input last, output ready);
endinterface

`default_nettype wire

[rtl/nnt_ram.sv]
// ----------------------------------------------------------------------------
// nnt_ram: generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/nnt_ctrl.sv]
// ----------------------------------------------------------------------------
// nnt_ctrl: tour sequencer
// Accepts items, steps through emit / row scan / update / close phases.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  input  wire nnt_pkg::sts_t sts,
  output nnt_pkg::cmd_t      cmd
);
  import nnt_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EMIT  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_DRAIN = 8'b0000_1000,
    ST_STEP  = 8'b0001_0000,
    ST_CLOSE = 8'b0010_0000,
    ST_CADD  = 8'b0100_0000,
    ST_FINAL = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RUN) begin
            cmd.run_init = 1'b1;
            state_nxt    = ST_EMIT;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_city = 1'b1;
          if (sts.more_steps) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_STEP;   // last compare lands here
      ST_STEP: begin
        cmd.step_upd = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_CLOSE: begin
        cmd.close_issue = 1'b1;
        state_nxt       = ST_CADD;
      end
      ST_CADD: begin
        cmd.close_add = 1'b1;
        state_nxt     = ST_FINAL;
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_city || cmd.emit_final) |-> sts.out_free)
    else $error("item emitted while output register busy");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_RUN) |=> !in_ready)
    else $error("input still open after run started");

  a_one_read_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_issue && cmd.close_issue))
    else $error("scan and close reads issued together");
`endif

endmodule

`default_nettype wire

[rtl/nnt_dpath.sv]
// ----------------------------------------------------------------------------
// nnt_dpath: tour datapath
// Distance RAM, visited set, min search over one row, length accumulator
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_dpath #(
  parameter int MAX_CITIES = 32,
  parameter int DIST_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [nnt_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [nnt_pkg::CITY_W-1:0]      in_from_city,
  input  wire logic [nnt_pkg::CITY_W-1:0]      in_to_city,
  input  wire logic [nnt_pkg::DIST_IN_W-1:0]   in_distance,
  input  wire nnt_pkg::cmd_t                   cmd,
  output nnt_pkg::sts_t                        sts,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic      [nnt_pkg::CITY_W-1:0]      out_city,
  output logic      [nnt_pkg::TOTAL_W-1:0]     out_total_distance,
  output logic                                 out_last
);
  import nnt_pkg::*;

  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int SW    = DIST_BITS + TOTAL_W + 1;

  // config and run state
  logic [CFG_W-1:0]      cfg_count_r;
  logic [NW-1:0]         n_r;
  logic [MAX_CITIES-1:0] vis_r;
  logic [CW-1:0]         cur_r;
  logic [NW-1:0]         step_r;
  logic [TOTAL_W-1:0]    len_r;
  logic [CW-1:0]         j_r;

  // compare stage
  logic                  cmp_v_r;
  logic [CW-1:0]         cmp_j_r;
  logic                  found_r;
  logic [CW-1:0]         best_r;
  logic [DIST_BITS-1:0]  best_d_r;

  // output register
  logic                  out_valid_r;
  logic [CITY_W-1:0]     out_city_r;
  logic [TOTAL_W-1:0]    out_total_r;
  logic                  out_last_r;

  // RAM ports
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DIST_BITS-1:0]  wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DIST_BITS-1:0]  rd_data;

  logic [DIST_IN_W+DIST_BITS-1:0] dist_ext;
  logic [NW-1:0]         n_clamp;
  logic                  take;
  logic [DIST_BITS-1:0]  add_d;
  logic [SW-1:0]         sum;
  logic [TOTAL_W-1:0]    len_sat;

  // load path; rows or columns beyond the table are dropped
  assign dist_ext = {{DIST_BITS{1'b0}}, in_distance};
  assign wr_data  = dist_ext[DIST_BITS-1:0];
  assign wr_en    = cmd.load_wr && (int'(in_from_city) < MAX_CITIES)
                                && (int'(in_to_city) < MAX_CITIES);
  assign wr_addr  = AW'(int'(in_from_city) * MAX_CITIES + int'(in_to_city));
  assign rd_addr  = AW'(int'(cur_r) * MAX_CITIES
                        + (cmd.close_issue ? 0 : int'(j_r)));

  nnt_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // zero runs as one city, oversize as the table size
  always_comb begin
    if (cfg_count_r == '0) begin
      n_clamp = NW'(1);
    end else if (int'(cfg_count_r) > MAX_CITIES) begin
      n_clamp = NW'(MAX_CITIES);
    end else begin
      n_clamp = NW'(cfg_count_r);
    end
  end

  assign take = cmp_v_r && !vis_r[cmp_j_r] && (!found_r || rd_data < best_d_r);

  // saturating length add, shared by step and close
  assign add_d   = cmd.close_add ? rd_data : best_d_r;
  assign sum     = SW'(len_r) + SW'(add_d);
  assign len_sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.more_steps = (SW'(step_r) + SW'(1)) < SW'(n_r);
  assign sts.scan_done  = (NW'(j_r) == n_r - NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= CFG_RESET;
      n_r         <= NW'(MAX_CITIES);
      vis_r       <= '0;
      cur_r       <= '0;
      step_r      <= '0;
      len_r       <= '0;
      j_r         <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
      if (cmd.run_init) begin
        n_r    <= n_clamp;
        vis_r  <= MAX_CITIES'(1);
        cur_r  <= '0;
        step_r <= '0;
        len_r  <= '0;
      end
      if (cmd.scan_start) begin
        j_r     <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan_issue) begin
        j_r <= j_r + CW'(1);
      end
      cmp_v_r <= cmd.scan_issue;
      if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.step_upd) begin
        vis_r[best_r] <= 1'b1;
        cur_r         <= best_r;
        step_r        <= step_r + NW'(1);
        len_r         <= len_sat;
      end
      if (cmd.close_add) begin
        len_r <= len_sat;
        cur_r <= '0;
      end
      if (cmd.emit_city || cmd.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_j_r <= j_r;
    if (take) begin
      best_r   <= cmp_j_r;
      best_d_r <= rd_data;
    end
    if (cmd.emit_city) begin
      out_city_r  <= CITY_W'(cur_r);
      out_total_r <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_final) begin
      out_city_r  <= '0;
      out_total_r <= len_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_city           = out_city_r;
  assign out_total_distance = out_total_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_step_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_upd |-> found_r)
    else $error("step taken with no unvisited candidate");

  a_step_new_city: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_upd |-> !vis_r[best_r])
    else $error("step revisits a city");

  a_last_is_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_city_r == '0))
    else $error("closing item not at city zero");
`endif

endmodule

`default_nettype wire

[rtl/nearest_neighbor_tour.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_tour: greedy nearest-neighbor tour builder
// Load items are accepted one per cycle, back to back, while no run is active.
// A run waits on output stalls; its first city is emitted from the emit state.
// Each step reads one row entry per cycle from the single distance read port.
// Sync active-low reset clears control and sets city_count to 32; the
// distance table has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_tour #(
  parameter int MAX_CITIES = 32,   // table is MAX_CITIES x MAX_CITIES
  parameter int DIST_BITS  = 16    // stored distance width
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  nnt_in_if.sink                         in_ch,
  nnt_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [nnt_pkg::CFG_W-1:0] cfg_wdata
);
  import nnt_pkg::*;

  // Controller owns sequencing, datapath owns all storage and arithmetic.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  nnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Loads write the RAM on the accepting edge; a run blocks input until
  // its closing item is in the output register.
  assign in_ch.ready = in_ready;

  nnt_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_from_city       (in_ch.from_city),
    .in_to_city         (in_ch.to_city),
    .in_distance        (in_ch.distance),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_city           (out_ch.city),
    .out_total_distance (out_ch.total_distance),
    .out_last           (out_ch.last)
  );

  // Row scan overlaps a waiting result: the output register holds the
  // current city while the next row is searched.

endmodule

`default_nettype wire
